// ===== hdl/dqp_pkg.sv =====
// shared types, codes and constants of the dns question parser
`default_nettype none

package dqp_pkg;

   // parse phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_LENGTH = 3'd1;
   localparam logic [2:0] PH_LABEL  = 3'd2;
   localparam logic [2:0] PH_TYPECL = 3'd3;
   localparam logic [2:0] PH_IGNORE = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_COUNTS    = 3'd1;
   localparam logic [2:0] ST_LABEL     = 3'd2;
   localparam logic [2:0] ST_NAME      = 3'd3;
   localparam logic [2:0] ST_TRUNCATED = 3'd4;

   // item kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register indexes
   localparam logic CSR_MAX_LABEL_LEN = 1'b0;
   localparam logic CSR_MAX_NAME_LEN  = 1'b1;

   localparam logic [5:0] MAX_LABEL_LEN_RESET = 6'd63;
   localparam logic [8:0] MAX_NAME_LEN_RESET  = 9'd256;

   localparam logic [7:0] DOT_CHAR = 8'd46;

   // header layout
   localparam logic [3:0] HDR_COUNTS_FIRST = 4'd4;
   localparam logic [3:0] HDR_QDCOUNT_LOW  = 4'd5;
   localparam logic [3:0] HDR_LAST         = 4'd11;
   localparam logic [1:0] QI_LAST          = 2'd3;

   typedef struct packed {
      logic [2:0]  phase;
      logic [3:0]  header_index;
      logic        count_error;
      logic [8:0]  name_position;
      logic [5:0]  label_remaining;
      logic        label_seen;
      logic [1:0]  question_index;
      logic [31:0] type_class_hold;
   } state_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  name_char;
      logic [8:0]  name_length;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [2:0]  status;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/dqp_req_if.sv =====
// input channel: one message byte per item
`default_nettype none

interface dqp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/dqp_rsp_if.sv =====
// result channel: name characters and the final status item
`default_nettype none

interface dqp_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  name_char;
   logic [8:0]  name_length;
   logic [15:0] query_type;
   logic [15:0] query_class;
   logic [2:0]  status;

   modport source (output valid, output item_kind, output name_char, output name_length,
                   output query_type, output query_class, output status, input ready);
   modport sink   (input valid, input item_kind, input name_char, input name_length,
                   input query_type, input query_class, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/dqp_step.sv =====
// per-byte parse step: next state and optional result item
`default_nettype none

module dqp_step (
   input  dqp_pkg::state_type  state_cur,
   input  logic [7:0]          byte_value,
   input  logic                last_byte,
   input  logic [5:0]          max_label_len,
   input  logic [8:0]          max_name_len,
   output dqp_pkg::state_type  state_nxt,
   output logic                res_valid,
   output dqp_pkg::result_type res
);
   import dqp_pkg::*;

   logic [7:0]  want;
   logic        cerr;
   logic [9:0]  name_sum;
   logic [5:0]  lrem_dec;
   logic [31:0] hold_nxt;

   function automatic result_type status_item(input logic [2:0] st, input logic [8:0] nlen,
                                              input logic [31:0] tc);
      result_type r;
      r = '0;
      r.item_kind = KIND_STATUS;
      r.status    = st;
      if (st == ST_OK) begin
         r.name_length = nlen;
         r.query_type  = tc[31:16];
         r.query_class = tc[15:0];
      end
      return r;
   endfunction

   function automatic result_type char_item(input logic [7:0] c);
      result_type r;
      r = '0;
      r.item_kind = KIND_CHAR;
      r.name_char = c;
      return r;
   endfunction

   assign want     = (state_cur.header_index == HDR_QDCOUNT_LOW) ? 8'd1 : 8'd0;
   assign cerr     = state_cur.count_error |
                     ((state_cur.header_index >= HDR_COUNTS_FIRST) && (byte_value != want));
   assign name_sum = {1'b0, state_cur.name_position} + {2'b00, byte_value} + 10'd1;
   assign lrem_dec = state_cur.label_remaining - 6'd1;
   assign hold_nxt = {state_cur.type_class_hold[23:0], byte_value};

   always_comb begin
      state_nxt = state_cur;
      res_valid = 1'b0;
      res       = '0;
      unique case (state_cur.phase)
         PH_HEADER: begin
            state_nxt.count_error = cerr;
            if (state_cur.header_index >= HDR_LAST) begin
               if (cerr) begin
                  res_valid       = 1'b1;
                  res             = status_item(ST_COUNTS, '0, '0);
                  state_nxt.phase = PH_IGNORE;
               end else begin
                  state_nxt.phase = PH_LENGTH;
               end
            end else begin
               state_nxt.header_index = state_cur.header_index + 4'd1;
            end
            if (last_byte && !res_valid) begin
               res_valid = 1'b1;
               res       = status_item(ST_TRUNCATED, '0, '0);
            end
         end
         PH_LENGTH: begin
            if (byte_value == 8'd0) begin
               // terminator
               state_nxt.name_position  = state_cur.name_position + 9'd1;
               state_nxt.phase          = PH_TYPECL;
               state_nxt.question_index = '0;
               state_nxt.type_class_hold = '0;
               res_valid = 1'b1;
               res = last_byte ? status_item(ST_TRUNCATED, '0, '0) : char_item(DOT_CHAR);
            end else if (byte_value > {2'b00, max_label_len}) begin
               res_valid       = 1'b1;
               res             = status_item(ST_LABEL, '0, '0);
               state_nxt.phase = PH_IGNORE;
            end else if (name_sum >= {1'b0, max_name_len}) begin
               res_valid       = 1'b1;
               res             = status_item(ST_NAME, '0, '0);
               state_nxt.phase = PH_IGNORE;
            end else begin
               if (last_byte) begin
                  res_valid = 1'b1;
                  res       = status_item(ST_TRUNCATED, '0, '0);
               end else if (state_cur.label_seen) begin
                  res_valid = 1'b1;
                  res       = char_item(DOT_CHAR);
               end
               state_nxt.name_position   = name_sum[8:0];
               state_nxt.label_remaining = byte_value[5:0];
               state_nxt.label_seen      = 1'b1;
               state_nxt.phase           = PH_LABEL;
            end
         end
         PH_LABEL: begin
            res_valid = 1'b1;
            res = last_byte ? status_item(ST_TRUNCATED, '0, '0) : char_item(byte_value);
            state_nxt.label_remaining = lrem_dec;
            if (lrem_dec == 6'd0) begin
               state_nxt.phase = PH_LENGTH;
            end
         end
         PH_TYPECL: begin
            state_nxt.type_class_hold = hold_nxt;
            if (state_cur.question_index >= QI_LAST) begin
               res_valid       = 1'b1;
               res             = status_item(ST_OK, state_cur.name_position, hold_nxt);
               state_nxt.phase = PH_IGNORE;
            end else begin
               state_nxt.question_index = state_cur.question_index + 2'd1;
               if (last_byte) begin
                  res_valid = 1'b1;
                  res       = status_item(ST_TRUNCATED, '0, '0);
               end
            end
         end
         default: begin
         end
      endcase
      // end of packet: wait for a fresh header
      if (last_byte) begin
         state_nxt       = '0;
         state_nxt.phase = PH_HEADER;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dns_question_parser.sv =====
// top level of the dns question parser: input register, parse step, result register
// path: an accepted item sits in the input register; its result, if any, is loaded into the
//   result register as the item leaves the input register, and is taken from there by rsp
// throughput: one byte item per cycle while the result register does not stall; the only loop is the parse state update
// a full result register that is not being taken stalls the input register, which stalls req through ready
// reset: synchronous active high, clears pipeline valids and parse state to header phase,
//   and sets max_label_len to 63 and max_name_len to 256
`default_nettype none

module dns_question_parser (
   input  logic        clock,
   input  logic        reset,
   dqp_req_if.sink     req_chan,
   dqp_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data
);
   import dqp_pkg::*;

   // configuration registers
   logic [5:0] max_label_ff, max_label_in;
   logic [8:0] max_name_ff, max_name_in;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // parse state
   state_type  state_ff, state_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic       out_free;
   logic       s1_adv;
   logic       req_take;
   logic       step_valid;
   result_type step_res;

   // result slot is free when empty or being taken this cycle
   assign out_free = !out_valid_ff || rsp_chan.ready;
   // the input register drains whenever the result slot can take its outcome
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   dqp_step u_step (
      .state_cur     (state_ff),
      .byte_value    (s1_byte_ff),
      .last_byte     (s1_last_ff),
      .max_label_len (max_label_ff),
      .max_name_len  (max_name_ff),
      .state_nxt     (state_in),
      .res_valid     (step_valid),
      .res           (step_res)
   );

   // register writes
   always_comb begin
      max_label_in = max_label_ff;
      max_name_in  = max_name_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_LABEL_LEN: max_label_in = csr_write_data[5:0];
            CSR_MAX_NAME_LEN:  max_name_in  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign out_valid_in = out_free ? (s1_adv && step_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_label_ff <= MAX_LABEL_LEN_RESET;
         max_name_ff  <= MAX_NAME_LEN_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         max_label_ff <= max_label_in;
         max_name_ff  <= max_name_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // state moves only as an item leaves the input register
         if (s1_adv) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.byte_value;
         s1_last_ff <= req_chan.last_byte;
      end
      if (s1_adv && step_valid) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.item_kind   = out_res_ff.item_kind;
   assign rsp_chan.name_char   = out_res_ff.name_char;
   assign rsp_chan.name_length = out_res_ff.name_length;
   assign rsp_chan.query_type  = out_res_ff.query_type;
   assign rsp_chan.query_class = out_res_ff.query_class;
   assign rsp_chan.status      = out_res_ff.status;

   // a failing status carries no name length, type or class
   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.item_kind == KIND_STATUS && out_res_ff.status != ST_OK)
      |-> (out_res_ff.name_length == 9'd0 && out_res_ff.query_type == 16'd0 &&
           out_res_ff.query_class == 16'd0))
      else $error("failing status item carries nonzero fields");

   // a name character item has no status fields
   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.item_kind == KIND_CHAR)
      |-> (out_res_ff.status == ST_OK && out_res_ff.name_length == 9'd0))
      else $error("name item carries status fields");

   // status code stays in its defined range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff.status <= ST_TRUNCATED))
      else $error("status code out of range");

   // the last byte of a packet returns the parser to a clean header phase
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (state_ff == '0))
      else $error("state not cleared after last byte");

endmodule

`default_nettype wire
